>>> rtl/sks_pkg.sv
// Package for the sorted key set: default sizes, request codes and the
// controller state type. No dependencies.
package sks_pkg;

  // Default store depth and key width.
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 31;

  // Width of the reported entry count.
  localparam int unsigned COUNT_OUT_W = 11;

  // Request codes; the fourth code is unused and does nothing.
  typedef enum logic [1:0] {
    OP_CONTAINS = 2'd0,
    OP_ADD      = 2'd1,
    OP_REMOVE   = 2'd2
  } opcode_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_FINISH,
    ST_RESP
  } state_e;

endpackage

>>> rtl/sorted_key_set_core.sv
// Sorted key set core: ordered key store in one synchronous memory with a
// scan-and-shift controller and a registered result stage.
// Depends on sks_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         in_valid_i / in_stall_o    opcode_i, key_i
//  result    out        out_valid_o / out_stall_i  success_o, full_res_o, entry_count_o
//
// A request is handled in steps, and its result may wait on out_stall_i:
// the lookup reads the memory one entry per cycle up to the first key not
// below the request key, and an insert or delete then moves the entries
// above that point one per cycle through the single read and write port.
// Reset empties the set at once; the memory contents need no clearing.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
module sorted_key_set_core #(
  parameter int unsigned CAPACITY = sks_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = sks_pkg::KEY_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic [KEY_BITS-1:0]              key_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             success_o,
  output logic                             full_res_o,
  output logic [sks_pkg::COUNT_OUT_W-1:0]  entry_count_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  // Key store.
  logic [KEY_BITS-1:0] mem_q [CAPACITY];

  sks_pkg::state_e state_q, state_d;

  logic [1:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    left_q, left_d;
  logic [AW-1:0]       src_q, src_d;
  logic                res_success_q, res_success_d;
  logic                res_full_q, res_full_d;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                rvalid_q;
  logic [AW-1:0]       raddr_q;
  logic [KEY_BITS-1:0] rdata_q;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  logic                out_valid_q;
  logic                out_success_q;
  logic                out_full_q;
  logic [CNT_W-1:0]    out_count_q;
  logic                out_load;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  // Read-valid flag is the read enable registered, in step with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_en;
    end
  end

  // Controller state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    key_q         <= key_d;
    scan_q        <= scan_d;
    pos_q         <= pos_d;
    left_q        <= left_d;
    src_q         <= src_d;
    res_success_q <= res_success_d;
    res_full_q    <= res_full_d;
  end

  // Next state, memory accesses and the decision after the lookup.
  always_comb begin
    logic hit;
    logic done;
    logic found;
    logic [CNT_W-1:0] pos_c;

    state_d       = state_q;
    op_d          = op_q;
    key_d         = key_q;
    count_d       = count_q;
    scan_d        = scan_q;
    pos_d         = pos_q;
    left_d        = left_q;
    src_d         = src_q;
    res_success_d = res_success_q;
    res_full_d    = res_full_q;
    rd_en         = 1'b0;
    rd_addr       = scan_q[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = raddr_q;
    wr_data       = rdata_q;
    out_load      = 1'b0;
    in_stall_o    = 1'b1;
    hit           = 1'b0;
    done          = 1'b0;
    found         = 1'b0;
    pos_c         = count_q;

    unique case (state_q)
      sks_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d    = opcode_i;
          key_d   = key_i;
          scan_d  = '0;
          state_d = sks_pkg::ST_SCAN;
        end
      end

      sks_pkg::ST_SCAN: begin
        // Check the returning entry against the request key.
        hit = rvalid_q && (rdata_q >= key_q);
        if (hit) begin
          done  = 1'b1;
          pos_c = CNT_W'(raddr_q);
          found = (rdata_q == key_q);
        end else if (scan_q == count_q) begin
          done  = 1'b1;
          pos_c = count_q;
        end
        // Issue the next read while entries remain and the lookup goes on,
        // so that no stale read reaches the move phase.
        if (!hit && (scan_q < count_q)) begin
          rd_en  = 1'b1;
          scan_d = scan_q + 1'b1;
        end

        if (done) begin
          pos_d         = pos_c;
          res_success_d = 1'b0;
          res_full_d    = 1'b0;
          state_d       = sks_pkg::ST_RESP;
          case (op_q)
            sks_pkg::OP_CONTAINS: begin
              res_success_d = found;
            end
            sks_pkg::OP_ADD: begin
              if (!found) begin
                if (count_q >= CapCount) begin
                  res_full_d = 1'b1;
                end else begin
                  res_success_d = 1'b1;
                  count_d       = count_q + 1'b1;
                  left_d        = count_q - pos_c;
                  src_d         = AW'(count_q - 1'b1);
                  state_d       = sks_pkg::ST_MOVE;
                end
              end
            end
            sks_pkg::OP_REMOVE: begin
              if (found) begin
                res_success_d = 1'b1;
                count_d       = count_q - 1'b1;
                left_d        = count_q - 1'b1 - pos_c;
                src_d         = AW'(pos_c + 1'b1);
                state_d       = sks_pkg::ST_MOVE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      sks_pkg::ST_MOVE: begin
        // Read the tail one entry a cycle and write each one a place over.
        rd_addr = src_q;
        if (left_q != '0) begin
          rd_en  = 1'b1;
          left_d = left_q - 1'b1;
          src_d  = (op_q == sks_pkg::OP_ADD) ? src_q - 1'b1 : src_q + 1'b1;
        end
        if (rvalid_q) begin
          wr_en   = 1'b1;
          wr_addr = (op_q == sks_pkg::OP_ADD) ? raddr_q + 1'b1 : raddr_q - 1'b1;
        end else if (left_q == '0) begin
          state_d = (op_q == sks_pkg::OP_ADD) ? sks_pkg::ST_FINISH : sks_pkg::ST_RESP;
        end
      end

      sks_pkg::ST_FINISH: begin
        // Place the new key in the opened slot.
        wr_en   = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = key_q;
        state_d = sks_pkg::ST_RESP;
      end

      sks_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = sks_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sks_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_success_q <= res_success_q;
      out_full_q    <= res_full_q;
      out_count_q   <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = out_success_q;
  assign full_res_o    = out_full_q;
  assign entry_count_o = sks_pkg::COUNT_OUT_W'(out_count_q);

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("key count above capacity");

  // A refused add reports no success and a full store.
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_res_o |-> !success_o && (out_count_q == CapCount))
    else $error("full result with wrong success or count");

  // The count changes only at the end of a lookup.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != sks_pkg::ST_SCAN |=> $stable(count_q))
    else $error("key count changed outside the lookup");

  // Memory writes happen only while moving entries or placing a key.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == sks_pkg::ST_MOVE) || (state_q == sks_pkg::ST_FINISH))
    else $error("memory write outside an update");

  // A taken request blocks the next one until its result is loaded.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");

endmodule

>>> test/tb_sorted_key_set_core.sv
// Testbench for sorted_key_set_core: random and directed contains, add and
// remove requests, checked against a predictor of the ordered key store.
// Depends on sks_pkg and the sorted_key_set_core RTL.
module tb_sorted_key_set_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = sks_pkg::CAPACITY_DEF;
  localparam int unsigned KEY_W    = sks_pkg::KEY_BITS_DEF;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam int POOL_SIZE = 48;
  localparam int RANDOM_REQS = 470;
  localparam int MAX_PRINTED = 50;
  // Worst case is about 600 requests, each scanning and moving up to CAPACITY entries, plus stalls.
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic             drain;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } set_request_t;

  typedef struct packed {
    logic                            success;
    logic                            full_res;
    logic [sks_pkg::COUNT_OUT_W-1:0] entry_count;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] opcode_i = sks_pkg::OP_CONTAINS;
  logic [KEY_W-1:0] key_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic success_o;
  logic full_res_o;
  logic [sks_pkg::COUNT_OUT_W-1:0] entry_count_o;

  set_request_t queued_requests[$];
  set_result_t  pending_results[$];
  int accepted_reqs = 0;
  int checked_results = 0;
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 1;
  logic [4:0]  stall_phase = '0;
  logic [31:0] stall_pattern = '0;

  // Predicted contents of the store.
  logic [KEY_W-1:0] held_keys [CAPACITY];
  int held_count = 0;

  sorted_key_set_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .success_o     (success_o),
    .full_res_o    (full_res_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one request to the predicted store and returns its result.
  function automatic set_result_t apply_to_key_set(logic [1:0] op, logic [KEY_W-1:0] k);
    set_result_t res;
    int pos;
    logic found;
    res = '0;
    pos = 0;
    while (pos < held_count && held_keys[pos] < k) pos++;
    found = (pos < held_count) && (held_keys[pos] == k);
    case (op)
      sks_pkg::OP_CONTAINS: begin
        res.success = found;
      end
      sks_pkg::OP_ADD: begin
        if (!found) begin
          if (held_count >= CAPACITY) begin
            res.full_res = 1'b1;
          end else begin
            for (int j = held_count; j > pos; j--) held_keys[j] = held_keys[j-1];
            held_keys[pos] = k;
            held_count++;
            res.success = 1'b1;
          end
        end
      end
      sks_pkg::OP_REMOVE: begin
        if (found) begin
          for (int j = pos; j + 1 < held_count; j++) held_keys[j] = held_keys[j+1];
          held_count--;
          res.success = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = sks_pkg::COUNT_OUT_W'(held_count);
    return res;
  endfunction

  function automatic void queue_request(logic [1:0] op, logic [KEY_W-1:0] k, logic hold);
    set_request_t req;
    req.drain = hold;
    req.op = op;
    req.key = k;
    queued_requests.push_back(req);
  endfunction

  // Printing stops after a while so a broken block cannot flood the log.
  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_PRINTED)
      $display("ERROR result %0d %s: got %0d, expected %0d", checked_results, what, got, want);
    mismatches++;
  endtask

  // Request driver: bursts of random length with random gaps between them.
  // A request marked drain waits until every earlier result has been checked.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    set_request_t nxt;
    logic take;
    int total;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i <= sks_pkg::OP_CONTAINS;
      key_i <= '0;
      accepted_reqs <= 0;
      gap_left <= 0;
      burst_left <= 1;
    end else begin
      take = in_valid_i && !in_stall_o;
      total = accepted_reqs;
      if (take) begin
        pending_results.push_back(apply_to_key_set(opcode_i, key_i));
        total = total + 1;
        accepted_reqs <= total;
      end
      if (!in_valid_i || take) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (queued_requests.size() == 0 ||
                     (queued_requests[0].drain && total != checked_results)) begin
          in_valid_i <= 1'b0;
        end else begin
          nxt = queued_requests.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= nxt.op;
          key_i <= nxt.key;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result monitor: checks each result and stalls from the bits of a random 32-bit pattern.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    set_result_t want;
    logic [31:0] pat;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      checked_results <= 0;
      stall_phase <= '0;
      stall_pattern <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_results <= checked_results + 1;
        if (pending_results.size() == 0) begin
          report_mismatch("arrived with no request waiting", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (success_o !== want.success)
            report_mismatch("success", success_o, want.success);
          if (full_res_o !== want.full_res)
            report_mismatch("full_res", full_res_o, want.full_res);
          if (entry_count_o !== want.entry_count)
            report_mismatch("entry_count", entry_count_o, want.entry_count);
        end
      end
      pat = stall_pattern;
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '0;
          1: pat = $urandom;
          2: pat = $urandom & $urandom;
          default: pat = $urandom | $urandom;
        endcase
      end
      stall_pattern <= pat;
      out_stall_i <= pat[stall_phase];
      stall_phase <= stall_phase + 1'b1;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] pool [POOL_SIZE];
    logic [KEY_W-1:0] touched [$];
    logic [KEY_W-1:0] k;
    logic [1:0] op;
    int r;
    int wait_cycles;
    logic done;

    // Directed: empty store, extreme keys, duplicates, absent removes, unused code.
    queue_request(sks_pkg::OP_CONTAINS, '0, 1'b0);
    queue_request(sks_pkg::OP_REMOVE, '0, 1'b0);
    queue_request(OP_UNUSED, KEY_MAX, 1'b0);
    queue_request(sks_pkg::OP_ADD, KEY_MAX, 1'b0);
    queue_request(sks_pkg::OP_ADD, '0, 1'b0);
    queue_request(sks_pkg::OP_ADD, '0, 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, '0, 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, KEY_MAX, 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, KEY_W'(1), 1'b0);
    queue_request(sks_pkg::OP_ADD, KEY_W'(32'h2AAA_AAAA), 1'b0);
    queue_request(sks_pkg::OP_ADD, KEY_W'(32'h5555_5555), 1'b1);
    queue_request(OP_UNUSED, '0, 1'b0);
    queue_request(sks_pkg::OP_REMOVE, KEY_W'(32'h2AAA_AAAA), 1'b0);
    queue_request(sks_pkg::OP_REMOVE, KEY_W'(32'h2AAA_AAAA), 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, KEY_W'(32'h5555_5555), 1'b0);
    queue_request(sks_pkg::OP_REMOVE, '0, 1'b0);
    queue_request(sks_pkg::OP_REMOVE, KEY_MAX, 1'b0);
    queue_request(sks_pkg::OP_REMOVE, KEY_W'(32'h5555_5555), 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, KEY_MAX, 1'b0);

    // Random: mostly keys from a small pool so that hits are common.
    pool[0] = '0;
    pool[1] = KEY_MAX;
    for (int i = 2; i < POOL_SIZE; i++)
      pool[i] = (i < 8) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = sks_pkg::OP_ADD;
      else if (r < 70) op = sks_pkg::OP_REMOVE;
      else if (r < 95) op = sks_pkg::OP_CONTAINS;
      else op = OP_UNUSED;
      if ($urandom_range(0, 4) == 0) begin
        k = KEY_W'($urandom);
        if (op == sks_pkg::OP_ADD) touched.push_back(k);
      end else begin
        k = pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      queue_request(op, k, $urandom_range(0, 49) == 0);
    end

    // Empty the store again.
    for (int i = 0; i < POOL_SIZE; i++) queue_request(sks_pkg::OP_REMOVE, pool[i], 1'b0);
    foreach (touched[i]) queue_request(sks_pkg::OP_REMOVE, touched[i], 1'b0);
    queue_request(sks_pkg::OP_CONTAINS, KEY_MAX, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to be checked.
    wait_cycles = 0;
    done = 1'b0;
    while (!done && wait_cycles < CYCLE_LIMIT) begin
      @(negedge clk_i);
      wait_cycles++;
      done = queued_requests.size() == 0 && !in_valid_i && accepted_reqs == checked_results;
    end

    if (!done) begin
      $display("Mismatches found");
    end else begin
      repeat (2 * CAPACITY + 16) @(negedge clk_i);
      if (pending_results.size() != 0)
        report_mismatch("results still outstanding", 0, pending_results.size());
      if (mismatches == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule
